>>> sv/ldpc_parity_encoder_checker_assert.svh
// assertion macros for the ldpc parity encoder/checker
// no dependencies; included by the top level only
`ifndef LDPC_PARITY_ENCODER_CHECKER_ASSERT_SVH
`define LDPC_PARITY_ENCODER_CHECKER_ASSERT_SVH
`ifndef SYNTH
// a holds at an edge implies b at the same edge
`define LPEC_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("lpec assertion failed");
// a holds at an edge implies b at the next edge
`define LPEC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("lpec assertion failed");
`else
`define LPEC_ASSERT_SAME(label, clk, rst_n, a, b)
`define LPEC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> sv/lpec_pkg.sv
// shared constants, op codes and types for the ldpc parity encoder/checker
// no dependencies
package lpec_pkg;

    localparam int CHECK_ROWS = 83;
    localparam int MSG_BITS   = 91;
    localparam int LO_W       = 64;
    localparam int MSG_HI_W   = MSG_BITS - LO_W;
    localparam int PAR_HI_W   = CHECK_ROWS - LO_W;
    localparam int ROW_W      = $clog2(CHECK_ROWS);
    localparam int CNT_W      = $clog2(CHECK_ROWS + 1);

    localparam logic [1:0] OP_LOAD_LOW  = 2'd0;
    localparam logic [1:0] OP_LOAD_HIGH = 2'd1;
    localparam logic [1:0] OP_ENCODE    = 2'd2;
    localparam logic [1:0] OP_CHECK     = 2'd3;

    // tag for one row of read data arriving from the row store
    typedef struct packed {
        logic             vld;
        logic             last;
        logic [ROW_W-1:0] idx;
    } t_step;

    // finished encode/check transaction
    typedef struct packed {
        logic [CHECK_ROWS-1:0] parity;
        logic [CNT_W-1:0]      passed;
        logic [CNT_W-1:0]      first;
        logic                  all_pass;
    } t_result;

endpackage

>>> sv/ldpc_parity_encoder_checker.sv
// ldpc (174,91) generator-matrix encoder and parity checker; needs lpec_pkg, submodules, assert header
// load transactions: result strobe in the cycle after the accepting edge, busy stays low
// encode/check: strobe after the sequencer, row-store read and tag, accumulator and output registers,
// the single row-store read port sweeping 83 rows one per cycle; busy held meanwhile, then dropped
// with the strobe; the receiver cannot stall; synchronous active-low reset clears control only,
// the row store is undefined until each row half is loaded
`include "ldpc_parity_encoder_checker_assert.svh"

module ldpc_parity_encoder_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_op,
    input  logic [6:0]                        i_row_index,
    input  logic [63:0]                       i_row_data,
    input  logic [63:0]                       i_msg_low,
    input  logic [26:0]                       i_msg_high,
    input  logic [63:0]                       i_par_low,
    input  logic [18:0]                       i_par_high,
    output logic                              o_valid,
    output logic [63:0]                       o_out_parity_low,
    output logic [18:0]                       o_out_parity_high,
    output logic [6:0]                        o_checks_passed,
    output logic [6:0]                        o_first_failure,
    output logic                              o_all_pass
);

    // transaction decode
    logic accept;
    logic is_load;
    logic row_ok;
    logic we_lo;
    logic we_hi;
    logic go;

    // row store and sweep
    logic                              rd_en;
    logic [lpec_pkg::ROW_W-1:0]        rd_addr;
    logic [lpec_pkg::LO_W-1:0]         row_lo;
    logic [lpec_pkg::MSG_HI_W-1:0]     row_hi;
    lpec_pkg::t_step                   step;
    logic                              acc_done;
    lpec_pkg::t_result                 acc_result;

    // control and output registers
    logic                              r_busy, n_busy;
    logic                              r_valid, n_valid;
    logic [lpec_pkg::CHECK_ROWS-1:0]   r_parity, n_parity;
    logic [lpec_pkg::CNT_W-1:0]        r_passed, n_passed;
    logic [lpec_pkg::CNT_W-1:0]        r_first, n_first;
    logic                              r_all, n_all;

    assign accept  = start & ~r_busy;
    assign is_load = (i_op == lpec_pkg::OP_LOAD_LOW) || (i_op == lpec_pkg::OP_LOAD_HIGH);
    // out-of-range rows are dropped but still answer with an all-zero result
    assign row_ok  = (i_row_index < lpec_pkg::ROW_W'(lpec_pkg::CHECK_ROWS));
    assign we_lo   = accept & row_ok & (i_op == lpec_pkg::OP_LOAD_LOW);
    assign we_hi   = accept & row_ok & (i_op == lpec_pkg::OP_LOAD_HIGH);
    assign go      = accept & ~is_load;

    // writes happen only while idle and reads only during a sweep, so the
    // busy flag is the interlock between the two ports of the row store
    lpec_row_mem u_mem (
        .i_clk      (i_clk),
        .i_we_lo    (we_lo),
        .i_we_hi    (we_hi),
        .i_waddr    (i_row_index),
        .i_wdata    (i_row_data),
        .i_rd_en    (rd_en),
        .i_raddr    (rd_addr),
        .o_rdata_lo (row_lo),
        .o_rdata_hi (row_hi)
    );

    lpec_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (go),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_step    (step)
    );

    lpec_accum u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (go),
        .i_is_check (i_op == lpec_pkg::OP_CHECK),
        .i_msg_low  (i_msg_low),
        .i_msg_high (i_msg_high),
        .i_par_rx   ({i_par_high, i_par_low}),
        .i_step     (step),
        .i_row_lo   (row_lo),
        .i_row_hi   (row_hi),
        .o_done     (acc_done),
        .o_result   (acc_result)
    );

    // result strobe: either a load acknowledgment or a finished sweep,
    // never both since loads are only taken while no sweep runs
    always_comb begin
        n_busy   = r_busy;
        n_valid  = 1'b0;
        n_parity = r_parity;
        n_passed = r_passed;
        n_first  = r_first;
        n_all    = r_all;
        if (go) begin
            n_busy = 1'b1;
        end
        if (accept && is_load) begin
            n_valid  = 1'b1;
            n_parity = '0;
            n_passed = '0;
            n_first  = '0;
            n_all    = 1'b0;
        end
        if (acc_done) begin
            n_busy   = 1'b0;
            n_valid  = 1'b1;
            n_parity = acc_result.parity;
            n_passed = acc_result.passed;
            n_first  = acc_result.first;
            n_all    = acc_result.all_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_parity <= n_parity;
        r_passed <= n_passed;
        r_first  <= n_first;
        r_all    <= n_all;
    end

    assign busy              = r_busy;
    assign o_valid           = r_valid;
    assign o_out_parity_low  = r_parity[lpec_pkg::LO_W-1:0];
    assign o_out_parity_high = r_parity[lpec_pkg::CHECK_ROWS-1:lpec_pkg::LO_W];
    assign o_checks_passed   = r_passed;
    assign o_first_failure   = r_first;
    assign o_all_pass        = r_all;

    // an encode or check transaction holds the block busy from the next cycle
    `LPEC_ASSERT_NEXT(a_go_busy, i_clk, i_rst_n, go, r_busy)
    // row store is never written and read in the same cycle
    `LPEC_ASSERT_SAME(a_mem_interlock, i_clk, i_rst_n, rd_en, !(we_lo || we_hi))
    // a sweep only runs while busy
    `LPEC_ASSERT_SAME(a_sweep_busy, i_clk, i_rst_n, step.vld, r_busy)
    // all-pass is consistent with the pass count
    `LPEC_ASSERT_SAME(a_all_pass, i_clk, i_rst_n, o_valid && o_all_pass,
        o_checks_passed == lpec_pkg::CNT_W'(lpec_pkg::CHECK_ROWS))

endmodule

>>> sv/lpec_row_mem.sv
// generator row store: low and high column halves, one write and one read port
// depends on lpec_pkg
module lpec_row_mem (
    input  logic                              i_clk,
    input  logic                              i_we_lo,
    input  logic                              i_we_hi,
    input  logic [lpec_pkg::ROW_W-1:0]        i_waddr,
    input  logic [lpec_pkg::LO_W-1:0]         i_wdata,
    input  logic                              i_rd_en,
    input  logic [lpec_pkg::ROW_W-1:0]        i_raddr,
    output logic [lpec_pkg::LO_W-1:0]         o_rdata_lo,
    output logic [lpec_pkg::MSG_HI_W-1:0]     o_rdata_hi
);

    logic [lpec_pkg::LO_W-1:0]     mem_lo [0:lpec_pkg::CHECK_ROWS-1];
    logic [lpec_pkg::MSG_HI_W-1:0] mem_hi [0:lpec_pkg::CHECK_ROWS-1];

    always_ff @(posedge i_clk) begin
        if (i_we_lo) begin
            mem_lo[i_waddr] <= i_wdata;
        end
        if (i_we_hi) begin
            // columns beyond the message width are dropped
            mem_hi[i_waddr] <= i_wdata[lpec_pkg::MSG_HI_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rdata_lo <= mem_lo[i_raddr];
            o_rdata_hi <= mem_hi[i_raddr];
        end
    end

endmodule

>>> sv/lpec_seq.sv
// row sweep sequencer: issues one row read per cycle and tags the returning data
// depends on lpec_pkg
module lpec_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    output logic                       o_rd_en,
    output logic [lpec_pkg::ROW_W-1:0] o_rd_addr,
    output lpec_pkg::t_step            o_step
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;
    localparam logic [lpec_pkg::ROW_W-1:0] LAST_ROW = lpec_pkg::ROW_W'(lpec_pkg::CHECK_ROWS - 1);

    logic                       r_state, n_state;
    logic [lpec_pkg::ROW_W-1:0] r_addr, n_addr;
    lpec_pkg::t_step            r_step, n_step;
    logic                       at_last;

    assign at_last   = (r_addr == LAST_ROW);
    assign o_rd_en   = (r_state == S_READ);
    assign o_rd_addr = r_addr;
    assign o_step    = r_step;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_step.vld  = o_rd_en;
        n_step.last = o_rd_en & at_last;
        n_step.idx  = r_addr;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state = S_READ;
                    n_addr  = '0;
                end
            end
            S_READ: begin
                if (at_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_step  <= n_step;
        end
    end

endmodule

>>> sv/lpec_accum.sv
// parity accumulator: one row parity per step, shifts in the computed parity
// and scores it against the received parity; depends on lpec_pkg
module lpec_accum (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go,
    input  logic                              i_is_check,
    input  logic [lpec_pkg::LO_W-1:0]         i_msg_low,
    input  logic [lpec_pkg::MSG_HI_W-1:0]     i_msg_high,
    input  logic [lpec_pkg::CHECK_ROWS-1:0]   i_par_rx,
    input  lpec_pkg::t_step                   i_step,
    input  logic [lpec_pkg::LO_W-1:0]         i_row_lo,
    input  logic [lpec_pkg::MSG_HI_W-1:0]     i_row_hi,
    output logic                              o_done,
    output lpec_pkg::t_result                 o_result
);

    localparam logic [lpec_pkg::CNT_W-1:0] NONE = lpec_pkg::CNT_W'(lpec_pkg::CHECK_ROWS);

    logic [lpec_pkg::LO_W-1:0]       r_msg_lo;
    logic [lpec_pkg::MSG_HI_W-1:0]   r_msg_hi;
    logic [lpec_pkg::CHECK_ROWS-1:0] r_rx;
    logic [lpec_pkg::CHECK_ROWS-1:0] r_parity;
    logic [lpec_pkg::CNT_W-1:0]      r_passed;
    logic [lpec_pkg::CNT_W-1:0]      r_first;
    logic                            r_chk;
    logic                            r_done;
    logic                            row_par;

    assign row_par = ^{i_row_lo & r_msg_lo, i_row_hi & r_msg_hi};

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_msg_lo <= i_msg_low;
            r_msg_hi <= i_msg_high;
            r_rx     <= i_par_rx;
            r_chk    <= i_is_check;
            r_parity <= '0;
            r_passed <= '0;
            r_first  <= NONE;
        end else if (i_step.vld) begin
            // row 0 ends up in bit 0 after the full sweep
            r_parity <= {row_par, r_parity[lpec_pkg::CHECK_ROWS-1:1]};
            r_rx     <= {1'b0, r_rx[lpec_pkg::CHECK_ROWS-1:1]};
            if (row_par == r_rx[0]) begin
                r_passed <= r_passed + 1'b1;
            end else if (r_first == NONE) begin
                r_first <= lpec_pkg::CNT_W'(i_step.idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_step.vld & i_step.last;
        end
    end

    assign o_done            = r_done;
    assign o_result.parity   = r_parity;
    assign o_result.passed   = r_chk ? r_passed : '0;
    assign o_result.first    = r_chk ? r_first : '0;
    assign o_result.all_pass = r_chk & (r_passed == NONE);

endmodule
